/* hw/rtl/sn3d_pkg.sv */
package sn3d_pkg;

	// Fixed widths of the channel words.
	localparam int COORD_W = 24;
	localparam int NOISE_W = 16;

	// Default fixed-point formats of the coordinates and of the result.
	localparam int DEF_COORD_FRAC_BITS = 12;
	localparam int DEF_OUT_FRAC_BITS = 14;

	// Internal widths: corner offsets in Q.16, gradient sums, squared distances, terms.
	localparam int Q_W = 19;
	localparam int G_W = 20;
	localparam int D2_W = 36;
	localparam int PR_W = 53;
	localparam int TERM_W = 56;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NOISE_W-1:0] noise_t;
	typedef logic signed [Q_W-1:0] q_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic [5:0] hash_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// Floor division by three: bias to a non-negative value, then an exact reciprocal.
	localparam logic [25:0] DIV3_OFS = 26'd25165824;
	localparam logic [25:0] DIV3_MUL = 26'd44739243;

	// 0.6 in Q.32, rounded.
	localparam logic [31:0] T_POINT_SIX = 32'h9999999A;

	function automatic logic [5:0] seed(input logic [2:0] idx);
		logic [5:0] s;
		case (idx)
			3'd0: s = 6'h15;
			3'd1: s = 6'h38;
			3'd2: s = 6'h32;
			3'd3: s = 6'h2c;
			3'd4: s = 6'h0d;
			3'd5: s = 6'h13;
			3'd6: s = 6'h07;
			3'd7: s = 6'h2a;
			default: s = 6'h15;
		endcase
		return s;
	endfunction

	// Only the low six bits of the hash select the gradient, so the sum wraps at six bits.
	function automatic hash_t cell_hash(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		hash_t h;
		h = seed({a[0], b[0], c[0]}) + seed({b[1], c[1], a[1]}) +
			seed({c[2], a[2], b[2]}) + seed({a[3], b[3], c[3]}) +
			seed({b[4], c[4], a[4]}) + seed({c[5], a[5], b[5]}) +
			seed({a[6], b[6], c[6]}) + seed({b[7], c[7], a[7]});
		return h;
	endfunction

	function automatic logic [25:0] div3_prep(input coord_t n);
		return {{2{n[COORD_W-1]}}, n} + DIV3_OFS;
	endfunction

	function automatic coord_t div3_fin(input logic [25:0] m);
		logic [51:0] prod;
		logic [24:0] q;
		prod = 52'(m) * 52'(DIV3_MUL);
		q = prod[51:27];
		return coord_t'(q[23:0] - 24'h800000);
	endfunction

	function automatic noise_t sat_noise(input logic signed [20:0] v);
		noise_t r;
		if (v > 21'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -21'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/sn3d_if.sv */
interface sn3d_point_if import sn3d_pkg::*; ();
	logic valid;
	logic ready;
	coord_t coord_x;
	coord_t coord_y;
	coord_t coord_z;

	modport source(output valid, output coord_x, output coord_y, output coord_z, input ready);
	modport sink(input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface sn3d_noise_if import sn3d_pkg::*; ();
	logic valid;
	logic ready;
	noise_t noise_value;

	modport source(output valid, output noise_value, input ready);
	modport sink(input valid, input noise_value, output ready);
endinterface

interface sn3d_cfg_if import sn3d_pkg::*; ();
	logic valid;
	logic ready;
	logic normalize_mode;

	modport source(output valid, output normalize_mode, input ready);
	modport sink(input valid, input normalize_mode, output ready);
endinterface

/* hw/rtl/sn3d_corner.sv */
module sn3d_corner import sn3d_pkg::*; (
	input logic clk,
	input logic en,
	input q_t q_x,
	input q_t q_y,
	input q_t q_z,
	input hash_t hash,
	output term_t term
);

	logic signed [2*Q_W-1:0] sq_x, sq_y, sq_z;
	q_t p_c, qq_c, r_c;
	logic signed [G_W-1:0] g_c;
	logic [1:0] b;
	logic [63:0] tt_c, t2t2_c;
	logic signed [32:0] t4x;
	logic signed [PR_W-1:0] pr_c;

	logic [D2_W-1:0] d2_s7;
	logic signed [G_W-1:0] g_s7, g_s8, g_s9, g_s10;
	logic [31:0] t_s8, t2_s9, t4_s10;
	logic neg_s8, neg_s9, neg_s10;
	logic signed [PR_W-1:0] pr_s11;
	term_t tm_s12;

	always_comb begin
		sq_x = q_x * q_x;
		sq_y = q_y * q_y;
		sq_z = q_z * q_z;
		b = hash[1:0];
		case (b)
			2'd1: begin
				p_c = q_x;
				qq_c = q_y;
				r_c = q_z;
			end
			2'd2: begin
				p_c = q_y;
				qq_c = q_z;
				r_c = q_x;
			end
			default: begin
				p_c = q_z;
				qq_c = q_x;
				r_c = q_y;
			end
		endcase
		if (hash[5] == hash[3]) p_c = -p_c;
		if (hash[5] == hash[4]) qq_c = -qq_c;
		if (hash[5] != (hash[4] ^ hash[3])) r_c = -r_c;
		if (b == 2'd0) begin
			g_c = G_W'(p_c) + G_W'(qq_c) + G_W'(r_c);
		end else if (!hash[2]) begin
			g_c = G_W'(p_c) + G_W'(qq_c);
		end else begin
			g_c = G_W'(p_c) + G_W'(r_c);
		end
		tt_c = 64'(t_s8) * 64'(t_s8);
		t2t2_c = 64'(t2_s9) * 64'(t2_s9);
		t4x = {1'b0, t4_s10};
		pr_c = t4x * g_s10;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s7 <= D2_W'(unsigned'(sq_x)) + D2_W'(unsigned'(sq_y)) +
				D2_W'(unsigned'(sq_z));
			g_s7 <= g_c;
			t_s8 <= 32'(D2_W'(T_POINT_SIX) - d2_s7);
			neg_s8 <= d2_s7 > D2_W'(T_POINT_SIX);
			g_s8 <= g_s7;
			t2_s9 <= tt_c[63:32];
			neg_s9 <= neg_s8;
			g_s9 <= g_s8;
			t4_s10 <= t2t2_c[63:32];
			neg_s10 <= neg_s9;
			g_s10 <= g_s9;
			pr_s11 <= neg_s10 ? '0 : pr_c;
			tm_s12 <= (TERM_W'(pr_s11) <<< 4) + (TERM_W'(pr_s11) <<< 3) + TERM_W'(pr_s11);
		end
	end

	assign term = tm_s12;

endmodule

/* hw/rtl/simplex_noise_3d_eval.sv */
// Simplex noise evaluator: one 3D point in, one noise sample out.
// The point channel carries coord_x, coord_y and coord_z in signed fixed point with
// COORD_FRAC_BITS fraction bits; a word is taken at a clock edge with valid and ready high.
// The noise channel returns noise_value in signed fixed point with OUT_FRAC_BITS fraction
// bits, saturated to 16 bits, one word for every point and in the same order.
// The cfg channel writes normalize_mode; it is always ready and should only be written
// while no point is in flight. Setting it maps the raw range onto roughly -1..1.
// Throughput is one point per clock while the skid register is empty. The datapath is
// a 16-stage pipeline. Stage depth is set by the widest step in a stage: a multiplier of
// up to 32x32 bits for the squares, the t^2 and t^4 products and the reciprocal divisions.
// After the output register sits a one-word skid register. When the receiver stalls,
// the skid fills and point.ready drops on the next cycle; the whole pipeline then holds
// with nothing lost or repeated, and it resumes as soon as the skid drains.
// Reset clears all valid bits, empties both output registers and sets normalize_mode to 0.
module simplex_noise_3d_eval import sn3d_pkg::*; #(
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
	parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	sn3d_cfg_if.sink cfg,
	sn3d_point_if.sink point,
	sn3d_noise_if.source noise
);

	// Working widths that follow from the coordinate and output formats.
	localparam int F = COORD_FRAC_BITS;
	localparam int L = 32 - OUT_FRAC_BITS;
	localparam int OW = F + 5;
	localparam int CW = 28 - F;
	localparam int EW = OW + 18;
	localparam int NSTG = 16;

	localparam logic signed [OW-1:0] SIX_U = OW'(64'd6 << F);
	localparam logic signed [EW-1:0] SIX_U_E = EW'(64'd6 << F);

	// Rescale constants: the offset folds in 248 * 2^OUT_FRAC_BITS and the half-LSB rounding.
	localparam logic [21:0] PH_OFS = 22'(248 * (1 << OUT_FRAC_BITS) + 782);
	localparam logic [30:0] NORM_OFS = 31'd409993216;
	localparam logic [21:0] NORM_MUL = 22'((64'd1 << 32) / 64'd1564);
	localparam logic [29:0] NORM_DIV = 30'd1564;

	logic en;
	logic [NSTG-1:0] vld_s;
	logic mode_q;

	// Stage signals. Index c counts the four simplex corners, n the three axes.
	logic signed [26:0] sum_c [3];
	logic [25:0] cm_s1 [3];
	logic signed [OW-1:0] crd_s1 [3], crd_s2 [3];
	logic signed [CW-1:0] cell_s2 [3];
	logic signed [CW+1:0] csum_c;
	logic signed [OW-1:0] dx_c [3];
	logic signed [OW-1:0] off6_s3 [3], off6_s4 [3];
	logic [7:0] cl_s3 [3], cl_s4 [3];
	axis_t hi_c, lo_c, hi_s4, lo_s4;
	logic a_c [4][3];
	logic [7:0] ac_c [4][3];
	logic signed [OW-1:0] e6_c [4][3];
	logic signed [EW-1:0] nn_c [4][3];
	logic [25:0] dm_s5 [4][3];
	hash_t h_s5 [4], h_s6 [4];
	q_t q_s6 [4][3];
	term_t term_c [4];
	term_t acc_s13;

	logic signed [40:0] hx_c;
	logic signed [17:0] hc_c, hc_s14;
	logic [L-1:0] l_c;
	logic [35:0] lp_c;
	logic [21:0] ph_s14;
	logic signed [20:0] rn_c, rn_s14, rn_s15, rn_s16;
	logic [29:0] mm_s15, mm_s16;
	logic [51:0] np_c;
	logic [19:0] q0_s16, qf_c;
	logic [29:0] rem_c;
	logic signed [20:0] resn_c;
	noise_t res_c;

	logic out_vld_q, skid_vld_q;
	noise_t out_q, skid_q;
	logic push, pop;

	// The pipeline moves whenever the skid register is free.
	assign en = !skid_vld_q;
	assign point.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg.valid) begin
			mode_q <= cfg.normalize_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-2:0], point.valid};
		end
	end

	// Skew: the cell index on each axis is floor((4X + Y + Z) / (3 * 2^F)).
	// The shift takes the floor by 2^F; the divide by three finishes in stage two.
	always_comb begin
		sum_c[0] = (27'(point.coord_x) <<< 2) + 27'(point.coord_y) + 27'(point.coord_z);
		sum_c[1] = 27'(point.coord_x) + (27'(point.coord_y) <<< 2) + 27'(point.coord_z);
		sum_c[2] = 27'(point.coord_x) + 27'(point.coord_y) + (27'(point.coord_z) <<< 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 3; n++) begin
				cm_s1[n] <= div3_prep(coord_t'(sum_c[n] >>> F));
			end
			crd_s1[0] <= OW'(point.coord_x);
			crd_s1[1] <= OW'(point.coord_y);
			crd_s1[2] <= OW'(point.coord_z);
			for (int n = 0; n < 3; n++) begin
				cell_s2[n] <= CW'(div3_fin(cm_s1[n]));
				crd_s2[n] <= crd_s1[n];
			end
		end
	end

	// Unskewed offsets at scale 6 * 2^F. Their true range is well inside OW bits, so the
	// arithmetic is done modulo 2^OW.
	always_comb begin
		csum_c = (CW+2)'(cell_s2[0]) + (CW+2)'(cell_s2[1]) + (CW+2)'(cell_s2[2]);
		for (int n = 0; n < 3; n++) begin
			dx_c[n] = crd_s2[n] - (OW'(cell_s2[n]) <<< F);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 3; n++) begin
				off6_s3[n] <= (dx_c[n] <<< 2) + (dx_c[n] <<< 1) + (OW'(csum_c) <<< F);
				cl_s3[n] <= cell_s2[n][7:0];
			end
		end
	end

	// Rank the offsets. Ties send the largest axis toward x and the smallest toward z.
	always_comb begin
		if (off6_s3[0] >= off6_s3[2]) begin
			hi_c = (off6_s3[0] >= off6_s3[1]) ? AXIS_X : AXIS_Y;
		end else begin
			hi_c = (off6_s3[1] >= off6_s3[2]) ? AXIS_Y : AXIS_Z;
		end
		if (off6_s3[0] < off6_s3[2]) begin
			lo_c = (off6_s3[0] < off6_s3[1]) ? AXIS_X : AXIS_Y;
		end else begin
			lo_c = (off6_s3[1] < off6_s3[2]) ? AXIS_Y : AXIS_Z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s4 <= hi_c;
			lo_s4 <= lo_c;
			for (int n = 0; n < 3; n++) begin
				off6_s4[n] <= off6_s3[n];
				cl_s4[n] <= cl_s3[n];
			end
		end
	end

	// Corner walk: origin, then a step on the largest axis, then on the middle axis,
	// then the far corner. Corner c is displaced by c/6 on each axis along the main diagonal.
	// Each offset is rounded to Q.16 as floor((e6 * 2^17 + 6u) / (12u)), u = 2^F.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int n = 0; n < 3; n++) begin
				case (c)
					0: a_c[c][n] = 1'b0;
					1: a_c[c][n] = (hi_s4 == axis_t'(n));
					2: a_c[c][n] = (lo_s4 != axis_t'(n));
					default: a_c[c][n] = 1'b1;
				endcase
				ac_c[c][n] = cl_s4[n] + 8'(a_c[c][n]);
				e6_c[c][n] = off6_s4[n] + OW'(64'(c) << F) - (a_c[c][n] ? SIX_U : '0);
				nn_c[c][n] = (EW'(e6_c[c][n]) <<< 17) + SIX_U_E;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				for (int n = 0; n < 3; n++) begin
					dm_s5[c][n] <= div3_prep(coord_t'(nn_c[c][n] >>> (F + 2)));
					q_s6[c][n] <= Q_W'(div3_fin(dm_s5[c][n]));
				end
				h_s5[c] <= cell_hash(ac_c[c][0], ac_c[c][1], ac_c[c][2]);
				h_s6[c] <= h_s5[c];
			end
		end
	end

	// One lane per corner: falloff, gradient and weighted term, six stages deep.
	for (genvar gc = 0; gc < 4; gc++) begin : g_corner
		sn3d_corner u_corner (
			.clk(clk),
			.en(en),
			.q_x(q_s6[gc][0]),
			.q_y(q_s6[gc][1]),
			.q_z(q_s6[gc][2]),
			.hash(h_s6[gc]),
			.term(term_c[gc])
		);
	end

	// Output scaling. The Q.48 sum, cut to Q.32, is split as h * 2^L + l. The high part is
	// clamped where the result saturates in either mode anyway, which keeps the rescale narrow.
	always_comb begin
		hx_c = 41'(acc_s13 >>> (16 + L));
		l_c = acc_s13[16+L-1:16];
		if (hx_c > 41'sd65536) begin
			hc_c = 18'sd65536;
		end else if (hx_c < -41'sd65536) begin
			hc_c = -18'sd65536;
		end else begin
			hc_c = hx_c[17:0];
		end
		lp_c = 36'(l_c) * 36'd2000;
		rn_c = 21'(hc_c) + 21'(l_c[L-1]);
		np_c = 52'(mm_s15) * 52'(NORM_MUL);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s13 <= term_c[0] + term_c[1] + term_c[2] + term_c[3];
			hc_s14 <= hc_c;
			ph_s14 <= 22'(lp_c >> L) + PH_OFS;
			rn_s14 <= rn_c;
			mm_s15 <= 30'(31'(hc_s14) * 31'sd2000 + 31'(ph_s14) + NORM_OFS);
			rn_s15 <= rn_s14;
			q0_s16 <= np_c[51:32];
			mm_s16 <= mm_s15;
			rn_s16 <= rn_s15;
		end
	end

	// The reciprocal quotient is low by at most one; a single compare fixes it.
	always_comb begin
		rem_c = mm_s16 - 30'(30'(q0_s16) * NORM_DIV);
		qf_c = q0_s16 + 20'(rem_c >= NORM_DIV);
		resn_c = 21'(qf_c) - 21'sd262144;
		res_c = mode_q ? sat_noise(resn_c) : sat_noise(rn_s16);
	end

	// Output register and skid register.
	assign push = en && vld_s[NSTG-1];
	assign pop = out_vld_q && noise.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop && skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else if (pop || !out_vld_q) begin
				out_vld_q <= push;
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_vld_q) begin
			out_q <= skid_q;
		end else if (pop || !out_vld_q) begin
			out_q <= res_c;
		end else if (push) begin
			skid_q <= res_c;
		end
	end

	assign noise.valid = out_vld_q;
	assign noise.noise_value = out_q;

endmodule

/* hw/rtl/sn3d_chk.sv */
module sn3d_chk import sn3d_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input noise_t out_data
);

	logic [4:0] inflight_q;

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 5'(in_valid && in_ready) - 5'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("noise word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("noise word changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 5'd0)
		else $error("noise word without an accepted point");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("point channel stalled without a stalled receiver");

endmodule

bind simplex_noise_3d_eval sn3d_chk u_sn3d_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(point.valid),
	.in_ready(point.ready),
	.out_valid(noise.valid),
	.out_ready(noise.ready),
	.out_data(noise.noise_value)
);
